// ===== sv/rde_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the repeating decimal expander.
// No dependencies; every RTL file but rde_checker imports this package.
package rde_pkg;

    // Field widths of the input and result words
    localparam int unsigned DEN_W       = 7;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned POS_W       = 6;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 24;
    // Width of remainder times ten (remainder stays below 2^DEN_W)
    localparam int unsigned PROD_W      = DEN_W + 4;
    // Default largest accepted denominator
    localparam int unsigned MAX_DEN_DEF = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_LOOK,
        ST_REP
    } t_state;

    // Which result word the datapath loads into the output register
    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_ERR,
        OUT_MID,
        OUT_END,
        OUT_REP
    } t_out_kind;

    typedef struct packed {
        logic      start;
        logic      div1;
        logic      keep_rep;
        t_out_kind out_kind;
    } t_cmd;

    typedef struct packed {
        logic bad_den;
        logic rem_zero;
        logic rem_seen;
    } t_sts;

endpackage

// ===== sv/rde_div.sv =====
`timescale 1ns / 1ps
// Two-step radix-4 divider: quotient digit and remainder of t / d, t < 10*d.
// Depends on rde_pkg.
module rde_div (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [rde_pkg::PROD_W-1:0] i_t,
    input  logic [rde_pkg::DEN_W-1:0]  i_d,
    output logic [rde_pkg::DIGIT_W-1:0] o_q,
    output logic [rde_pkg::DEN_W-1:0]  o_rem
);
    import rde_pkg::*;

    localparam int unsigned P_W = DEN_W + 2;

    logic [PROD_W-1:0] d4;
    logic [PROD_W-1:0] d8;
    logic [1:0]        n_qh;
    logic [P_W-1:0]    n_part;
    logic [1:0]        r_qh;
    logic [P_W-1:0]    r_part;
    logic [P_W-1:0]    d1;
    logic [P_W-1:0]    d2;
    logic [P_W-1:0]    d3;
    logic [1:0]        ql;
    logic [P_W-1:0]    rem_w;

    // First step: upper two quotient bits against 8d and 4d
    always_comb begin
        d4 = PROD_W'({i_d, 2'b00});
        d8 = PROD_W'({i_d, 3'b000});
        if (i_t >= d8) begin
            n_qh   = 2'd2;
            n_part = P_W'(i_t - d8);
        end else if (i_t >= d4) begin
            n_qh   = 2'd1;
            n_part = P_W'(i_t - d4);
        end else begin
            n_qh   = 2'd0;
            n_part = P_W'(i_t);
        end
    end

    // Hold the partial remainder between the two steps
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_qh   <= n_qh;
            r_part <= n_part;
        end
    end

    // Second step: lower two quotient bits against 3d, 2d and d
    always_comb begin
        d1 = P_W'(i_d);
        d2 = P_W'({i_d, 1'b0});
        d3 = d1 + d2;
        if (r_part >= d3) begin
            ql    = 2'd3;
            rem_w = r_part - d3;
        end else if (r_part >= d2) begin
            ql    = 2'd2;
            rem_w = r_part - d2;
        end else if (r_part >= d1) begin
            ql    = 2'd1;
            rem_w = r_part - d1;
        end else begin
            ql    = 2'd0;
            rem_w = r_part;
        end
        o_q   = {r_qh, ql};
        o_rem = DEN_W'(rem_w);
    end

endmodule

// ===== sv/rde_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: remainder and step registers, seen bits, first-step memory,
// divider and output word register. Depends on rde_pkg and rde_div.
module rde_datapath #(
    parameter int unsigned MAX_DEN = rde_pkg::MAX_DEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rde_pkg::DEN_W-1:0]     i_den,
    input  rde_pkg::t_cmd                 i_cmd,
    output rde_pkg::t_sts                 o_sts,
    output logic [rde_pkg::DIGIT_W-1:0]   o_digit,
    output logic [rde_pkg::POS_W-1:0]     o_position,
    output logic                          o_last,
    output logic                          o_repeating,
    output logic [rde_pkg::POS_W-1:0]     o_repeat_start,
    output logic                          o_bad
);
    import rde_pkg::*;

    localparam int unsigned RW = (MAX_DEN > 1) ? $clog2(MAX_DEN) : 1;
    localparam int unsigned SW = RW;
    localparam int unsigned CW = (DEN_W > RW + 1) ? DEN_W : RW + 1;

    logic [DEN_W-1:0]   r_d;
    logic [RW-1:0]      r_rem;
    logic [SW-1:0]      r_step;
    logic [MAX_DEN-1:0] r_seen;
    logic [DIGIT_W-1:0] r_digit;
    logic [SW-1:0]      r_rd;
    logic [SW-1:0]      mem_step [MAX_DEN];

    logic [PROD_W-1:0]  rem_ext;
    logic [PROD_W-1:0]  prod;
    logic [DIGIT_W-1:0] div_q;
    logic [DEN_W-1:0]   div_rem;
    logic [RW-1:0]      rem_next;
    logic [CW-1:0]      den_ext;

    // Remainder times ten as shift and add
    assign rem_ext = PROD_W'(r_rem);
    assign prod    = (rem_ext << 3) + (rem_ext << 1);

    rde_div u_div (
        .i_clk  (i_clk),
        .i_load (i_cmd.div1),
        .i_t    (prod),
        .i_d    (r_d),
        .o_q    (div_q),
        .o_rem  (div_rem)
    );

    // Status back to the controller
    always_comb begin
        den_ext          = CW'(i_den);
        rem_next         = RW'(div_rem);
        o_sts.bad_den    = (den_ext < CW'(2)) || (den_ext > CW'(MAX_DEN));
        o_sts.rem_zero   = (div_rem == '0);
        o_sts.rem_seen   = r_seen[rem_next];
    end

    // Seen bits: clear for each run, mark on each division start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_cmd.start) begin
            r_seen <= '0;
        end else if (i_cmd.div1) begin
            r_seen[r_rem] <= 1'b1;
        end
    end

    // First-step memory: write at division start, read at current remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.div1) begin
            mem_step[r_rem] <= r_step;
        end
        r_rd <= mem_step[r_rem];
    end

    // Run registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_d    <= i_den;
            r_rem  <= RW'(1);
            r_step <= '0;
        end else if (i_cmd.out_kind == OUT_MID) begin
            r_rem  <= rem_next;
            r_step <= SW'(r_step + 1'b1);
        end else if (i_cmd.keep_rep) begin
            r_rem   <= rem_next;
            r_digit <= div_q;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.out_kind)
            OUT_ERR: begin
                o_digit        <= '0;
                o_position     <= '0;
                o_last         <= 1'b1;
                o_repeating    <= 1'b0;
                o_repeat_start <= '0;
                o_bad          <= 1'b1;
            end
            OUT_MID, OUT_END: begin
                o_digit        <= div_q;
                o_position     <= POS_W'(r_step);
                o_last         <= (i_cmd.out_kind == OUT_END);
                o_repeating    <= 1'b0;
                o_repeat_start <= '0;
                o_bad          <= 1'b0;
            end
            OUT_REP: begin
                o_digit        <= r_digit;
                o_position     <= POS_W'(r_step);
                o_last         <= 1'b1;
                o_repeating    <= 1'b1;
                o_repeat_start <= POS_W'(r_rd);
                o_bad          <= 1'b0;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== sv/rde_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences the division steps of a run and owns both handshakes.
// Depends on rde_pkg.
module rde_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    output logic          o_m_valid,
    input  logic          i_m_ready,
    input  rde_pkg::t_sts i_sts,
    output rde_pkg::t_cmd o_cmd
);
    import rde_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_m_ready;
    assign o_m_valid = r_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.start    = 1'b0;
        o_cmd.div1     = 1'b0;
        o_cmd.keep_rep = 1'b0;
        o_cmd.out_kind = OUT_NONE;
        o_s_ready      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready = slot_free;
                if (i_s_valid && slot_free) begin
                    if (i_sts.bad_den) begin
                        o_cmd.out_kind = OUT_ERR;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_DIV1;
                    end
                end
            end
            ST_DIV1: begin
                o_cmd.div1 = 1'b1;
                n_state    = ST_DIV2;
            end
            ST_DIV2: begin
                if (i_sts.rem_zero) begin
                    if (slot_free) begin
                        o_cmd.out_kind = OUT_END;
                        n_state        = ST_IDLE;
                    end
                end else if (i_sts.rem_seen) begin
                    o_cmd.keep_rep = 1'b1;
                    n_state        = ST_LOOK;
                end else if (slot_free) begin
                    o_cmd.out_kind = OUT_MID;
                    n_state        = ST_DIV1;
                end
            end
            ST_LOOK: begin
                n_state = ST_REP;
            end
            ST_REP: begin
                if (slot_free) begin
                    o_cmd.out_kind = OUT_REP;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the output word until taken
    always_comb begin
        if (o_cmd.out_kind != OUT_NONE) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

// ===== sv/repeating_decimal_expander.sv =====
`timescale 1ns / 1ps
// Top level of the repeating decimal expander: digits of 1/d by long division.
// Depends on rde_pkg, rde_ctrl, rde_datapath (and rde_div below it).
//
//  Channel  Dir  Word                          Fields (low bit first)
//  s_axis   in   one denominator               tdata: denominator[6:0]
//  m_axis   out  one digit of 1/d              tdata: digit, position, is_repeating,
//                                              repeat_start; tlast: last_digit;
//                                              tuser: bad_denominator
//
// Each digit passes through ST_DIV1 and ST_DIV2, one per radix-4 step of the divider.
// A repeating run then passes through ST_LOOK and ST_REP to read the first-step memory.
// A bad denominator yields a single error word straight from idle.
// Synchronous active-low reset returns to idle with no word pending.
// A stalled output holds the controller; a new denominator is taken only
// when idle and the output register is free or being emptied.
module repeating_decimal_expander #(
    parameter int unsigned MAX_DEN = rde_pkg::MAX_DEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // denominator [6:0], zeros [7]
    input  logic [rde_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // digit [3:0], position [9:4], is_repeating [10], repeat_start [16:11], zeros [23:17]
    output logic [rde_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast,
    // bad_denominator [0]
    output logic                            m_axis_tuser
);
    import rde_pkg::*;

    t_cmd               cmd;
    t_sts               sts;
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   position;
    logic               repeating;
    logic [POS_W-1:0]   repeat_start;

    rde_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    rde_datapath #(
        .MAX_DEN (MAX_DEN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_den          (s_axis_tdata[DEN_W-1:0]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_digit        (digit),
        .o_position     (position),
        .o_last         (m_axis_tlast),
        .o_repeating    (repeating),
        .o_repeat_start (repeat_start),
        .o_bad          (m_axis_tuser)
    );

    // Pack the result word
    assign m_axis_tdata = M_TDATA_W'({repeat_start, repeating, position, digit});

endmodule

// ===== sv/rde_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the repeating decimal expander, bound to the top.
// Depends on the top level's port list only.
module rde_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // A pending word stays until taken
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // An error word ends its run and carries no digit
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tlast && (m_axis_tdata[16:0] == 17'd0))
        else $error("malformed error word");

    // Digits are decimal
    a_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <= 4'd9))
        else $error("digit out of range");

    // Repeat information only on the final word
    a_rep_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            (m_axis_tdata[16:10] == 7'd0))
        else $error("repeat fields set before the final word");

    // Repeat start never lies beyond the final position
    a_rep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10] |->
            (m_axis_tdata[16:11] <= m_axis_tdata[9:4]))
        else $error("repeat start after final position");

endmodule

bind repeating_decimal_expander rde_checker u_rde_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/repeating_decimal_expander_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for repeating_decimal_expander: feeds denominators, predicts each
// digit word of 1/d by long division and compares every field. Depends on rde_pkg and the RTL.
module repeating_decimal_expander_test;

    localparam int unsigned MAX_DEN      = rde_pkg::MAX_DEN_DEF;
    localparam int unsigned DEN_W        = rde_pkg::DEN_W;
    localparam int unsigned RANDOM_ITEMS = 197;
    localparam int unsigned PAUSE_AT     = 150;
    localparam int unsigned HOLD_AT      = 60;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned TAIL_CYCLES  = 200;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_PATTERN
    } t_rx_mode;

    // Expected digit words of 1/d, oldest first
    class t_fraction_digits_board;
        typedef struct packed {
            logic [3:0] digit;
            logic [5:0] position;
            logic       last;
            logic       repeating;
            logic [5:0] start;
            logic       bad;
        } t_digit_word;

        t_digit_word awaited[$];
        int unsigned errors;

        // Append one expected word at the tail
        function void queue_word(t_digit_word w);
            awaited.insert(awaited.size(), w);
        endfunction

        // Expand 1/den by long division and queue one word per digit
        function void take_denominator(logic [DEN_W-1:0] den);
            bit          marked [MAX_DEN];
            bit [5:0]    first_step [MAX_DEN];
            int unsigned rem;
            int unsigned step;
            int unsigned prod;
            t_digit_word w;
            w = '0;
            if (den < 2 || den > MAX_DEN) begin
                w.last = 1'b1;
                w.bad  = 1'b1;
                queue_word(w);
                return;
            end
            rem    = 1;
            step   = 0;
            marked = '{default: 1'b0};
            for (int n = 0; n < MAX_DEN; n++) begin
                marked[rem]     = 1'b1;
                first_step[rem] = step[5:0];
                prod            = rem * 10;
                w               = '0;
                w.digit         = 4'(prod / den);
                w.position      = step[5:0];
                rem             = prod % den;
                // terminating: remainder ran out
                if (rem == 0) begin
                    w.last = 1'b1;
                    queue_word(w);
                    break;
                end
                // repeating: remainder came back
                if (marked[rem]) begin
                    w.last      = 1'b1;
                    w.repeating = 1'b1;
                    w.start     = first_step[rem];
                    queue_word(w);
                    break;
                end
                queue_word(w);
                step++;
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one output word against the oldest expectation
        function void check_digit(logic [rde_pkg::M_TDATA_W-1:0] data, logic last, logic bad);
            t_digit_word w;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual tdata 0x%0h last %0b bad %0b",
                         $time, data, last, bad);
                errors++;
                return;
            end
            w = awaited.pop_front();
            compare_field("digit", w.digit, data[3:0]);
            compare_field("position", w.position, data[9:4]);
            compare_field("is_repeating", w.repeating, data[10]);
            compare_field("repeat_start", w.start, data[16:11]);
            compare_field("last_digit", w.last, last);
            compare_field("bad_denominator", w.bad, bad);
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // denominator [6:0], zeros [7]
    logic [rde_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // digit [3:0], position [9:4], is_repeating [10], repeat_start [16:11], zeros [23:17]
    logic [rde_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tlast;
    // bad_denominator [0]
    logic                          m_axis_tuser;

    t_fraction_digits_board digits = new();
    int unsigned            words_taken;
    int unsigned            idle_cycles;
    bit                     held_off;

    repeating_decimal_expander dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hold the word until the block takes it
    task automatic offer_denominator(logic [DEN_W-1:0] den);
        s_axis_tdata  <= {1'b0, den};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Wait until every expected word has come out
    task automatic drain_results();
        do @(posedge i_clk); while (digits.pending() != 0);
    endtask

    // Mostly legal denominators, a few below two or above the limit
    function automatic logic [DEN_W-1:0] pick_denominator();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return DEN_W'($urandom_range(0, 1));
        else if (pick < 8)
            return DEN_W'($urandom_range(MAX_DEN + 1, 127));
        return DEN_W'($urandom_range(2, MAX_DEN));
    endfunction

    // Watch both channels, predict on input, check on output
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (s_axis_tvalid && s_axis_tready) begin
                digits.take_denominator(s_axis_tdata[DEN_W-1:0]);
                words_taken++;
                idle_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                digits.check_digit(m_axis_tdata, m_axis_tlast, m_axis_tuser);
                idle_cycles = 0;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Receiver: alternate stall patterns, one long hold-off partway through
    initial begin
        t_rx_mode    mode;
        int unsigned span;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (!held_off && words_taken >= HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                held_off = 1'b1;
            end
            mode = t_rx_mode'($urandom_range(0, 2));
            span = $urandom_range(10, 150);
            for (int k = 0; k < span; k++) begin
                case (mode)
                    RX_STEADY:  m_axis_tready <= 1'b1;
                    RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: m_axis_tready <= (k % 7) < 4;
                    default:    m_axis_tready <= 1'b1;
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Sender: reset, directed denominators, then random bursts
    initial begin
        logic [DEN_W-1:0] directed [$];
        int unsigned      sent;
        int unsigned      burst;
        directed = '{0, 1, 2, 3, 6, 7, 10, 11, 12, 16, 17, 28, 48, 49, 59, 61, 63, 64,
                     65, 100, 127, 13, 40};
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: errors, terminating, pure and mixed repeating, longest runs
        foreach (directed[i])
            offer_denominator(directed[i]);
        s_axis_tvalid <= 1'b0;
        drain_results();

        // Random bursts with gaps; one full drain partway through
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                offer_denominator(pick_denominator());
                sent++;
                if (sent == PAUSE_AT) begin
                    s_axis_tvalid <= 1'b0;
                    drain_results();
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then watch for stray words
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (digits.errors == 0 && digits.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rde_pkg.sv
sv/rde_div.sv
sv/rde_datapath.sv
sv/rde_ctrl.sv
sv/repeating_decimal_expander.sv
sv/rde_checker.sv
verif/repeating_decimal_expander_test.sv
